// ===== hw/rtl/hpt_pkg.sv =====
// shared constants and types for the homogeneous point transform
`default_nettype none

package hpt_pkg;

	localparam int FRAC_BITS = 16;
	localparam int MAT_DIM   = 5;
	localparam int MAT_SIZE  = MAT_DIM * MAT_DIM;
	localparam int DATA_W    = 32;
	localparam int IDX_W     = 5;
	localparam int PROD_W    = 2 * DATA_W;
	// five products plus headroom
	localparam int SUM_W     = PROD_W + 3;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_POINT = 1'b1;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef logic [IDX_W-1:0]         idx_t;

	localparam data_t COEF_ONE = data_t'(1 << FRAC_BITS);
	localparam data_t DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam data_t DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

endpackage

`default_nettype wire

// ===== hw/rtl/hpt_if.sv =====
// input and result channel interfaces of the point transform
`default_nettype none

interface hpt_in_if;
	logic                valid;
	logic                ready;
	logic                cmd;
	hpt_pkg::idx_t       coef_index;
	hpt_pkg::data_t      coef_value;
	hpt_pkg::data_t      point_a;
	hpt_pkg::data_t      point_b;
	hpt_pkg::data_t      point_c;
	hpt_pkg::data_t      point_d;
	hpt_pkg::data_t      point_w;

	modport source (
		output valid, cmd, coef_index, coef_value,
		output point_a, point_b, point_c, point_d, point_w,
		input  ready
	);
	modport sink (
		input  valid, cmd, coef_index, coef_value,
		input  point_a, point_b, point_c, point_d, point_w,
		output ready
	);
endinterface

interface hpt_out_if;
	logic                valid;
	logic                ready;
	hpt_pkg::data_t      out_a;
	hpt_pkg::data_t      out_b;
	hpt_pkg::data_t      out_c;
	hpt_pkg::data_t      out_d;
	hpt_pkg::data_t      out_w;
	logic                saturated;

	modport source (
		output valid, out_a, out_b, out_c, out_d, out_w, saturated,
		input  ready
	);
	modport sink (
		input  valid, out_a, out_b, out_c, out_d, out_w, saturated,
		output ready
	);
endinterface

`default_nettype wire

// ===== hw/rtl/homogeneous_point_transform_5x5_top.sv =====
// 5x5 homogeneous point transform with stored coefficient matrix
//
//   channel  | dir | contents
//   ---------+-----+-----------------------------------------------------
//   point    | in  | cmd, coef_index, coef_value, point_a..point_d, point_w
//   result   | out | out_a..out_d, out_w, saturated
//
// five register stages: input, 25 products, pairwise sums, row sums, output
// one beat per cycle unless result.ready back-pressure stalls the pipeline;
// a point's result passes the stages above in order and leaves from the output
// register; a coefficient write takes effect for the next point beat accepted
// each stage stalls on its own, so bubbles close up under back-pressure
// reset loads the identity matrix and empties the pipeline
`default_nettype none

module homogeneous_point_transform_5x5_top (
	input  wire        clk,
	input  wire        arst_n,
	hpt_in_if.sink     point,
	hpt_out_if.source  result
);

	localparam int DIM  = hpt_pkg::MAT_DIM;
	localparam int SIZE = hpt_pkg::MAT_SIZE;

	hpt_pkg::data_t coef_q [SIZE];

	hpt_pkg::data_t pt_s1   [DIM];
	hpt_pkg::prod_t prod_s2 [DIM][DIM];
	hpt_pkg::sum_t  pa_s3   [DIM];
	hpt_pkg::sum_t  pb_s3   [DIM];
	hpt_pkg::sum_t  pc_s3   [DIM];
	hpt_pkg::sum_t  sum_s4  [DIM];
	hpt_pkg::data_t res_s5  [DIM];
	logic           sat_s5;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;

	logic wr_acc;
	logic pt_acc;

	hpt_pkg::sum_t  shifted [DIM];
	logic           hi_clip [DIM];
	logic           lo_clip [DIM];
	hpt_pkg::data_t res_d   [DIM];
	logic           sat_d;

	assign rdy_s5 = !v_s5 || result.ready;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;

	assign point.ready = rdy_s1;
	assign wr_acc = point.valid && rdy_s1 && (point.cmd == hpt_pkg::CMD_WRITE);
	assign pt_acc = point.valid && rdy_s1 && (point.cmd == hpt_pkg::CMD_POINT);

	// coefficient store; the products stage reads it only when stage 1 moves,
	// and a write can land only when stage 1 is empty or moves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SIZE; i++) begin
				coef_q[i] <= (i % (DIM + 1) == 0) ? hpt_pkg::COEF_ONE : '0;
			end
		end else if (wr_acc && (point.coef_index < hpt_pkg::idx_t'(SIZE))) begin
			coef_q[point.coef_index] <= point.coef_value;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= pt_acc;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
		end
	end

	// stage 1: point register
	always_ff @(posedge clk) begin
		if (pt_acc) begin
			pt_s1[0] <= point.point_a;
			pt_s1[1] <= point.point_b;
			pt_s1[2] <= point.point_c;
			pt_s1[3] <= point.point_d;
			pt_s1[4] <= point.point_w;
		end
	end

	// stage 2: one product per coefficient
	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			for (int r = 0; r < DIM; r++) begin
				for (int k = 0; k < DIM; k++) begin
					prod_s2[r][k] <= hpt_pkg::prod_t'(coef_q[r*DIM + k]) *
						hpt_pkg::prod_t'(pt_s1[k]);
				end
			end
		end
	end

	// stage 3: pairwise sums
	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			for (int r = 0; r < DIM; r++) begin
				pa_s3[r] <= hpt_pkg::sum_t'(prod_s2[r][0]) + hpt_pkg::sum_t'(prod_s2[r][1]);
				pb_s3[r] <= hpt_pkg::sum_t'(prod_s2[r][2]) + hpt_pkg::sum_t'(prod_s2[r][3]);
				pc_s3[r] <= hpt_pkg::sum_t'(prod_s2[r][4]);
			end
		end
	end

	// stage 4: full-precision row sums
	always_ff @(posedge clk) begin
		if (rdy_s4 && v_s3) begin
			for (int r = 0; r < DIM; r++) begin
				sum_s4[r] <= pa_s3[r] + pb_s3[r] + pc_s3[r];
			end
		end
	end

	// floor shift, then clip to 32 bits
	always_comb begin
		sat_d = 1'b0;
		for (int r = 0; r < DIM; r++) begin
			shifted[r] = sum_s4[r] >>> hpt_pkg::FRAC_BITS;
			hi_clip[r] = shifted[r] > hpt_pkg::sum_t'(hpt_pkg::DATA_MAX);
			lo_clip[r] = shifted[r] < hpt_pkg::sum_t'(hpt_pkg::DATA_MIN);
			if (hi_clip[r]) begin
				res_d[r] = hpt_pkg::DATA_MAX;
			end else if (lo_clip[r]) begin
				res_d[r] = hpt_pkg::DATA_MIN;
			end else begin
				res_d[r] = shifted[r][hpt_pkg::DATA_W-1:0];
			end
			sat_d = sat_d | hi_clip[r] | lo_clip[r];
		end
	end

	// stage 5: output register
	always_ff @(posedge clk) begin
		if (rdy_s5 && v_s4) begin
			for (int r = 0; r < DIM; r++) begin
				res_s5[r] <= res_d[r];
			end
			sat_s5 <= sat_d;
		end
	end

	assign result.valid     = v_s5;
	assign result.out_a     = res_s5[0];
	assign result.out_b     = res_s5[1];
	assign result.out_c     = res_s5[2];
	assign result.out_d     = res_s5[3];
	assign result.out_w     = res_s5[4];
	assign result.saturated = sat_s5;

`ifndef SYNTHESIS
	// the flag only rises when some component sits on a bound
	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && sat_s5 |->
			res_s5[0] == hpt_pkg::DATA_MAX || res_s5[0] == hpt_pkg::DATA_MIN ||
			res_s5[1] == hpt_pkg::DATA_MAX || res_s5[1] == hpt_pkg::DATA_MIN ||
			res_s5[2] == hpt_pkg::DATA_MAX || res_s5[2] == hpt_pkg::DATA_MIN ||
			res_s5[3] == hpt_pkg::DATA_MAX || res_s5[3] == hpt_pkg::DATA_MIN ||
			res_s5[4] == hpt_pkg::DATA_MAX || res_s5[4] == hpt_pkg::DATA_MIN)
		else $error("saturated flag without a clipped component");

	// an in-range write is visible in the store on the next cycle
	a_coef_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr_acc && (point.coef_index < hpt_pkg::idx_t'(SIZE)) |=>
			coef_q[$past(point.coef_index)] == $past(point.coef_value))
		else $error("coefficient write lost");

	// a stalled point in stage 1 is not dropped
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !rdy_s2 |=> v_s1)
		else $error("stage 1 beat dropped under stall");

	// the input side only backs up when every stage is occupied
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!point.ready |-> v_s1 && v_s2 && v_s3 && v_s4 && v_s5)
		else $error("input stalled with a free stage");
`endif

endmodule

`default_nettype wire
